/* sv/itoa_pkg.sv */
// Shared types, constants and the shift-add-3 step for the integer to ASCII converter.
package itoa_pkg;

  localparam int VALUE_W    = 32;
  localparam int BCD_DIGITS = 10;
  localparam int BCD_W      = 4 * BCD_DIGITS;
  localparam int NDIG_W     = 4;
  localparam int CHAR_W     = 6;
  localparam int DD_STEPS   = 8;
  localparam int DD_STAGES  = VALUE_W / DD_STEPS;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 6'd45;

  typedef struct packed {
    logic               neg;
    logic [BCD_W-1:0]   bcd;
    logic [VALUE_W-1:0] bin;
  } work_t;

  typedef struct packed {
    logic              neg;
    logic [BCD_W-1:0]  bcd;
    logic [NDIG_W-1:0] ndig;
  } norm_t;

  function automatic work_t dd_step(work_t w);
    work_t      r;
    logic [3:0] d;
    r = w;
    for (int i = 0; i < BCD_DIGITS; i++) begin
      d = r.bcd[4*i +: 4];
      if (d >= 4'd5) begin
        r.bcd[4*i +: 4] = d + 4'd3;
      end
    end
    {r.bcd, r.bin} = {r.bcd[BCD_W-2:0], r.bin, 1'b0};
    return r;
  endfunction

endpackage

/* sv/itoa_dd_stage.sv */
// One pipeline stage that runs several shift-add-3 steps of the binary to BCD conversion.
module itoa_dd_stage (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  itoa_pkg::work_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output itoa_pkg::work_t out_data
);

  itoa_pkg::work_t stepped;

  always_comb begin
    stepped = in_data;
    for (int s = 0; s < itoa_pkg::DD_STEPS; s++) begin
      stepped = itoa_pkg::dd_step(stepped);
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
      if (in_valid) begin
        out_data <= stepped;
      end
    end
  end

endmodule

/* sv/itoa_serializer.sv */
// Character serializer that emits the sign and the digits of one number, one per transaction.
module itoa_serializer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  itoa_pkg::norm_t               in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [itoa_pkg::CHAR_W-1:0]   out_char,
  output logic                          out_last
);

  logic                          busy;
  logic                          sign_pend;
  logic [itoa_pkg::BCD_W-1:0]    sbcd;
  logic [itoa_pkg::NDIG_W-1:0]   left;
  logic                          produce;
  logic                          finishing;

  assign produce   = busy && (!out_valid || out_ready);
  assign finishing = produce && !sign_pend && (left == 4'd1);
  assign in_ready  = !busy || finishing;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
      sign_pend <= 1'b0;
    end else begin
      if (produce) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (produce) begin
        if (sign_pend) begin
          out_char <= itoa_pkg::ASCII_MINUS;
          out_last <= 1'b0;
        end else begin
          out_char <= itoa_pkg::ASCII_ZERO
                      + {2'b00, sbcd[itoa_pkg::BCD_W-1 -: 4]};
          out_last <= (left == 4'd1);
        end
      end
      if (in_valid && in_ready) begin
        busy      <= 1'b1;
        sign_pend <= in_data.neg;
        sbcd      <= in_data.bcd;
        left      <= in_data.ndig;
      end else if (produce) begin
        if (sign_pend) begin
          sign_pend <= 1'b0;
        end else begin
          sbcd <= {sbcd[itoa_pkg::BCD_W-5:0], 4'd0};
          left <= left - 4'd1;
          if (left == 4'd1) begin
            busy <= 1'b0;
          end
        end
      end
    end
  end

endmodule

/* sv/signed_int_to_decimal_ascii.sv */
// Top level: signed 32-bit integer to decimal ASCII text, pipelined conversion and serializer.
//
//   Channel   Dir   tdata (low bit up)          tuser   tlast
//   s_axis    in    value[31:0]                 -       -
//   m_axis    out   char_code[5:0], 2'b00       -       last_char
//
// A number passes an input stage, four BCD stages of eight shift-add-3 steps each and a
// leading-zero stage, and is then loaded into the serializer, whose output register holds
// its first character.
// The serializer emits one character per cycle while m_axis is ready, so a number takes
// 1 to 11 characters (digit count plus one for a minus sign); that sets the sustained rate.
// Reset clears all valid bits; on an m_axis stall a full stage waits for a free successor.
module signed_int_to_decimal_ascii (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // value[31:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // char_code[5:0], zeros[7:6]
  output logic        m_axis_tlast
);

  localparam int NS = itoa_pkg::DD_STAGES;

  logic [NS:0]                   v;
  logic [NS:0]                   rdy;
  itoa_pkg::work_t               d [NS+1];
  logic                          in_vld;
  itoa_pkg::work_t               in_item;
  logic                          raw_neg;
  logic [itoa_pkg::VALUE_W-1:0]  raw_mag;
  logic                          nv;
  itoa_pkg::norm_t               norm;
  itoa_pkg::norm_t               norm_next;
  logic                          ser_ready;
  logic [itoa_pkg::CHAR_W-1:0]   out_char;
  logic [3:0]                    top_idx;
  logic [3:0]                    shift_digits;

  assign raw_neg = s_axis_tdata[itoa_pkg::VALUE_W-1];
  assign raw_mag = raw_neg ? (32'd0 - s_axis_tdata) : s_axis_tdata;

  assign s_axis_tready = !in_vld || rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld <= s_axis_tvalid;
      if (s_axis_tvalid) begin
        in_item <= '{neg: raw_neg, bcd: '0, bin: raw_mag};
      end
    end
  end

  assign v[0] = in_vld;
  assign d[0] = in_item;

  for (genvar k = 0; k < NS; k++) begin : g_dd
    itoa_dd_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (v[k]),
      .in_ready  (rdy[k]),
      .in_data   (d[k]),
      .out_valid (v[k+1]),
      .out_ready (rdy[k+1]),
      .out_data  (d[k+1])
    );
  end

  always_comb begin
    top_idx = 4'd0;
    for (int i = 0; i < itoa_pkg::BCD_DIGITS; i++) begin
      if (d[NS].bcd[4*i +: 4] != 4'd0) begin
        top_idx = 4'(i);
      end
    end
    shift_digits   = 4'(itoa_pkg::BCD_DIGITS - 1) - top_idx;
    norm_next.neg  = d[NS].neg;
    norm_next.bcd  = d[NS].bcd << {shift_digits, 2'b00};
    norm_next.ndig = top_idx + 4'd1;
  end

  assign rdy[NS] = !nv || ser_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      nv <= 1'b0;
    end else if (rdy[NS]) begin
      nv <= v[NS];
      if (v[NS]) begin
        norm <= norm_next;
      end
    end
  end

  itoa_serializer u_ser (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (nv),
    .in_ready  (ser_ready),
    .in_data   (norm),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_char  (out_char),
    .out_last  (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, out_char};

  a_char_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (out_char == itoa_pkg::ASCII_MINUS)
                   || (out_char >= 6'd48 && out_char <= 6'd57))
    else $error("Output character is neither a digit nor a minus sign.");

  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (out_char == itoa_pkg::ASCII_MINUS) |-> !m_axis_tlast)
    else $error("Minus sign flagged as the last character.");

  a_digit_after_minus: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && (out_char == itoa_pkg::ASCII_MINUS)
    |=> m_axis_tvalid && (out_char != itoa_pkg::ASCII_MINUS))
    else $error("A digit did not follow the minus sign transaction.");

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for the signed integer to decimal ASCII converter.
module tb_top;

  localparam int RANDOM_ITEMS = 200;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 1000000;

  typedef struct {
    logic [itoa_pkg::CHAR_W-1:0] code;
    logic                        last;
  } char_item_t;

  typedef struct {
    logic [itoa_pkg::VALUE_W-1:0] value;
    string                        text;
  } stim_row_t;

  localparam int NUM_ROWS = 21;

  stim_row_t directed_rows [NUM_ROWS] = '{
    '{32'd0,          "0"},
    '{32'd1,          "1"},
    '{32'd9,          "9"},
    '{32'd10,         "10"},
    '{-32'sd1,        "-1"},
    '{-32'sd9,        "-9"},
    '{-32'sd10,       "-10"},
    '{32'd99,         "99"},
    '{32'd100,        "100"},
    '{32'd999999999,  "999999999"},
    '{32'd1000000000, "1000000000"},
    '{-32'sd1000000000, "-1000000000"},
    '{32'h7FFF_FFFF,  "2147483647"},
    '{32'h8000_0001,  "-2147483647"},
    '{32'h8000_0000,  "-2147483648"},
    '{32'h7FFF_FFFE,  "2147483646"},
    '{32'h5555_5555,  ""},
    '{32'hAAAA_AAAA,  ""},
    '{32'd1234567890, ""},
    '{-32'sd987654321, ""},
    '{32'h7FFF_0000,  ""}
  };

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [31:0]        s_axis_tdata = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [7:0]         m_axis_tdata;
  logic               m_axis_tlast;

  char_item_t pending_chars [$];
  int         fail_count = 0;
  int         accepted_items = 0;
  int         cycle_count = 0;
  bit         hold_done = 1'b0;

  signed_int_to_decimal_ascii dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever begin
      #5 clk = ~clk;
    end
  end

  function automatic void predict_text(input logic [itoa_pkg::VALUE_W-1:0] value);
    logic [itoa_pkg::VALUE_W-1:0] mag;
    logic [3:0]                   digit [itoa_pkg::BCD_DIGITS];
    char_item_t                   item;
    int                           ndig;
    bit                           neg;
    neg  = value[itoa_pkg::VALUE_W-1];
    mag  = neg ? (32'd0 - value) : value;
    ndig = 0;
    do begin
      digit[ndig] = 4'(mag % 32'd10);
      ndig++;
      mag = mag / 32'd10;
    end while (mag != 0);
    if (neg) begin
      item.code = itoa_pkg::ASCII_MINUS;
      item.last = 1'b0;
      pending_chars.push_back(item);
    end
    for (int k = ndig - 1; k >= 0; k--) begin
      item.code = itoa_pkg::ASCII_ZERO + itoa_pkg::CHAR_W'(digit[k]);
      item.last = (k == 0);
      pending_chars.push_back(item);
    end
  endfunction

  function automatic void push_text(input string text);
    char_item_t item;
    byte        c;
    for (int i = 0; i < text.len(); i++) begin
      c         = text[i];
      item.code = c[itoa_pkg::CHAR_W-1:0];
      item.last = (i == text.len() - 1);
      pending_chars.push_back(item);
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [itoa_pkg::VALUE_W-1:0] random_value();
    logic [itoa_pkg::VALUE_W-1:0] v;
    int                           kind;
    kind = $urandom_range(0, 9);
    if (kind < 4) begin
      v = $urandom;
    end else if (kind < 7) begin
      v = $urandom_range(0, 999);
    end else if (kind < 9) begin
      v = 32'd1;
      repeat ($urandom_range(0, 9)) v = v * 32'd10;
      v = v + $urandom_range(0, 2) - 32'd1;
    end else begin
      v = 32'h7FFF_FFFF - $urandom_range(0, 3);
    end
    if ($urandom_range(0, 1) == 1) begin
      v = 32'd0 - v;
    end
    return v;
  endfunction

  task automatic send_value(input logic [itoa_pkg::VALUE_W-1:0] value, input string text,
                            input int gap);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    if (text.len() > 0) begin
      push_text(text);
    end else begin
      predict_text(value);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    accepted_items++;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int i = 0; i < NUM_ROWS; i++) begin
      send_value(directed_rows[i].value, directed_rows[i].text, pick_gap());
    end
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      send_value(random_value(), "", (i >= 100 && i < 140) ? 0 : pick_gap());
    end
    s_axis_tvalid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_chars.size() != 0) begin
      $error("%0d characters never arrived", pending_chars.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // The long hold-off lets the sender fill the pipeline until input is stalled.
  initial begin
    int gap;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (!hold_done && accepted_items >= 80) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
        gap = pick_gap();
        if (gap > 0) begin
          m_axis_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    char_item_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_chars.size() == 0) begin
        $error("unexpected character transaction: char_code %0d",
               m_axis_tdata[itoa_pkg::CHAR_W-1:0]);
        fail_count++;
      end else begin
        want = pending_chars.pop_front();
        if (m_axis_tdata[itoa_pkg::CHAR_W-1:0] !== want.code) begin
          $error("char_code: expected %0d, actual %0d", want.code,
                 m_axis_tdata[itoa_pkg::CHAR_W-1:0]);
          fail_count++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last_char: expected %0d, actual %0d", want.last, m_axis_tlast);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $error("timeout after %0d cycles", cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

endmodule

/* filelist.f */
sv/itoa_pkg.sv
sv/itoa_dd_stage.sv
sv/itoa_serializer.sv
sv/signed_int_to_decimal_ascii.sv
tb/sv/tb_top.sv
